### sv/imlp_pkg.sv
`timescale 1ns / 1ps

package imlp_pkg;

    localparam int PREFIX_BYTES  = 256;
    localparam int NICK_BYTES    = 32;
    localparam int HOST_BYTES    = 64;
    localparam int LINE_BYTES    = 512;
    localparam int COMMAND_BYTES = 32;

    localparam int CNT_W = 12;
    localparam int POS_W = 9;
    localparam int Q_DEPTH = 3;
    localparam int QC_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] PFX_LIM   = CNT_W'(PREFIX_BYTES - 1);
    localparam logic [CNT_W-1:0] PFX_SIZE  = CNT_W'(PREFIX_BYTES);
    localparam logic [CNT_W-1:0] NICK_SIZE = CNT_W'(NICK_BYTES);
    localparam logic [CNT_W-1:0] HOST_SIZE = CNT_W'(HOST_BYTES);
    localparam logic [CNT_W-1:0] LINE_LIM  = CNT_W'(LINE_BYTES - 1);
    localparam logic [CNT_W-1:0] CMD_LIM   = CNT_W'(COMMAND_BYTES - 1);

    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_PREFIX = 3'd1,
        PH_PRESP  = 3'd2,
        PH_CMD    = 3'd3,
        PH_CMDSP  = 3'd4,
        PH_PARAMS = 3'd5,
        PH_TRAIL  = 3'd6,
        PH_DROP   = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        FLD_PREFIX = 3'd0,
        FLD_CMD    = 3'd1,
        FLD_PARAMS = 3'd2,
        FLD_TRAIL  = 3'd3,
        FLD_DELIM  = 3'd4
    } t_field;

    typedef enum logic [1:0] {
        PP_NICK = 2'd0,
        PP_USER = 2'd1,
        PP_HOST = 2'd2,
        PP_SEP  = 2'd3
    } t_part;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_PFX_LONG  = 3'd2,
        ST_PART_LONG = 3'd3,
        ST_CMD_LONG  = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_line;
    } t_in;

    typedef struct packed {
        logic [7:0]       out_byte;
        t_field           field;
        logic [POS_W-1:0] position;
        logic             keep;
        t_part            prefix_part;
        logic             user_form;
        logic             trail_found;
        logic             params_truncated;
        logic             trailing_truncated;
        t_status          status;
        logic             last;
    } t_out;

    typedef struct packed {
        logic [QC_W-1:0] cnt;
        t_out            res0;
        t_out            res1;
    } t_prs_out;

    typedef struct packed {
        logic line_start;
        logic held;
    } t_prs_stat;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        return (x == CNT_MAX) ? x : x + 1'b1;
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic [CNT_W-1:0] x,
                                                 input logic [CNT_W-1:0] lim);
        logic [CNT_W-1:0] m;
        m = (x < lim) ? x : lim;
        return m[POS_W-1:0];
    endfunction

    function automatic t_out mk_res(input logic [7:0] b, input t_field fld,
                                    input logic [POS_W-1:0] pos, input logic keep,
                                    input t_part part, input logic uf,
                                    input logic trail, input logic ptr,
                                    input logic ttr, input t_status st);
        t_out r;
        r.out_byte           = b;
        r.field              = fld;
        r.position           = pos;
        r.keep               = keep;
        r.prefix_part        = part;
        r.user_form          = uf;
        r.trail_found        = trail;
        r.params_truncated   = ptr;
        r.trailing_truncated = ttr;
        r.status             = st;
        r.last               = 1'b0;
        return r;
    endfunction

endpackage

### sv/irc_message_line_parser.sv
`timescale 1ns / 1ps
// Streaming splitter for IRC message lines, one byte per input transfer.
// Input channel: i_in_valid / o_in_stall with i_in_data (byte and end-of-line
// mark). Output channel: o_out_valid / i_out_stall with o_out_data, one
// result per transfer, last set on the final result of each line.
// A byte gives zero, one or two results: a space inside params is held until
// the next byte shows whether it opens the trailing part.
// The input register takes each byte; the byte is parsed once the three-entry
// output queue has room, and its results are offered from the queue head.
// Throughput: one byte per cycle while each byte gives at most one result and the
// receiver does not stall; a byte with two results holds off the next. The output
// queue sets the pace: a byte is parsed when two queue entries are free.
// When the receiver stalls, results stay in the queue in order, then the
// input register holds its byte and o_in_stall rises; nothing is dropped.
// Reset (synchronous, active low) empties the queue and the input register
// and returns the parser to the start of a line.
module irc_message_line_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  imlp_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output imlp_pkg::t_out o_out_data
);
    import imlp_pkg::*;

    logic            r_in_valid;
    t_in             r_in;
    logic            fire;
    logic            room;
    logic            in_xfer;
    t_prs_out        prs_res;
    t_prs_stat       prs_stat;
    logic [QC_W-1:0] push_cnt;

    assign fire       = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign push_cnt   = fire ? prs_res.cnt : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
    end

    imlp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_res   (prs_res),
        .o_stat  (prs_stat)
    );

    imlp_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_d0       (prs_res.res0),
        .i_d1       (prs_res.res1),
        .i_stall    (i_out_stall),
        .o_valid    (o_out_valid),
        .o_data     (o_out_data),
        .o_room     (room)
    );

    a_eol_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in.end_of_line |=> prs_stat.line_start)
        else $error("parser state not cleared after end of line");

    a_eol_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in.end_of_line |-> prs_res.cnt != '0)
        else $error("final byte of a line produced no result");

    a_silent_means_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && prs_res.cnt == '0 |=> prs_stat.held)
        else $error("byte produced no result without holding a space");

endmodule

### sv/imlp_parser.sv
`timescale 1ns / 1ps

module imlp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  imlp_pkg::t_in     i_item,
    output imlp_pkg::t_prs_out o_res,
    output imlp_pkg::t_prs_stat o_stat
);
    import imlp_pkg::*;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_fc, n_fc;
    logic [CNT_W-1:0] r_nick, n_nick;
    logic [CNT_W-1:0] r_user, n_user;
    logic [CNT_W-1:0] r_host, n_host;
    logic             r_bang, n_bang;
    logic             r_atb, n_atb;
    logic             r_ata, n_ata;
    logic             r_held, n_held;
    t_status          r_status, n_status;
    logic             r_trail, n_trail;
    logic             r_ptr, n_ptr;
    logic             r_ttr, n_ttr;

    logic [7:0]       b;
    logic             eol;
    logic             v_cmd;
    logic             v_drop;
    logic             v_skip;
    t_status          v_drop_st;
    t_part            v_part;
    t_out             v_res0, v_res1, v_tmp;
    logic [QC_W-1:0]  v_cnt;
    logic             uf;

    always_comb begin
        n_phase  = r_phase;
        n_fc     = r_fc;
        n_nick   = r_nick;
        n_user   = r_user;
        n_host   = r_host;
        n_bang   = r_bang;
        n_atb    = r_atb;
        n_ata    = r_ata;
        n_held   = r_held;
        n_status = r_status;
        n_trail  = r_trail;
        n_ptr    = r_ptr;
        n_ttr    = r_ttr;
        b         = i_item.in_byte;
        eol       = i_item.end_of_line;
        v_cmd     = 1'b0;
        v_drop    = 1'b0;
        v_skip    = 1'b0;
        v_drop_st = ST_OK;
        v_part    = PP_NICK;
        v_res0    = '0;
        v_res1    = '0;
        v_tmp     = '0;
        v_cnt     = '0;
        uf        = r_bang && r_ata && !r_atb;

        case (r_phase)
            PH_START: begin
                if (b == CH_COLON) begin
                    if (eol) begin
                        v_drop    = 1'b1;
                        v_drop_st = ST_NO_SPACE;
                    end else begin
                        n_phase = PH_PREFIX;
                        n_fc    = '0;
                        v_res0  = mk_res(b, FLD_DELIM, '0, 1'b0, PP_NICK, uf,
                                         n_trail, n_ptr, n_ttr, n_status);
                        v_cnt   = 2'd1;
                    end
                end else if (b == CH_SPACE) begin
                    n_phase = PH_CMDSP;
                    v_res0  = mk_res(b, FLD_DELIM, '0, 1'b0, PP_NICK, uf,
                                     n_trail, n_ptr, n_ttr, n_status);
                    v_cnt   = 2'd1;
                end else begin
                    v_cmd = 1'b1;
                end
            end
            PH_PREFIX: begin
                if (b == CH_SPACE) begin
                    if (r_fc >= PFX_SIZE) begin
                        v_drop    = 1'b1;
                        v_drop_st = ST_PFX_LONG;
                    end else if (uf && (r_nick >= NICK_SIZE || r_user >= NICK_SIZE ||
                                        r_host >= HOST_SIZE)) begin
                        v_drop    = 1'b1;
                        v_drop_st = ST_PART_LONG;
                    end else begin
                        n_phase = PH_PRESP;
                        n_fc    = '0;
                        v_res0  = mk_res(b, FLD_DELIM, '0, 1'b0, PP_NICK, uf,
                                         n_trail, n_ptr, n_ttr, n_status);
                        v_cnt   = 2'd1;
                    end
                end else if (eol) begin
                    v_drop    = 1'b1;
                    v_drop_st = ST_NO_SPACE;
                end else begin
                    if (r_atb) begin
                        n_nick = sat_inc(r_nick);
                    end else if (!r_bang) begin
                        if (b == CH_BANG) begin
                            n_bang = 1'b1;
                            v_part = PP_SEP;
                        end else begin
                            if (b == CH_AT) begin
                                n_atb = 1'b1;
                            end
                            n_nick = sat_inc(r_nick);
                        end
                    end else if (!r_ata) begin
                        if (b == CH_AT) begin
                            n_ata  = 1'b1;
                            v_part = PP_SEP;
                        end else begin
                            v_part = PP_USER;
                            n_user = sat_inc(r_user);
                        end
                    end else begin
                        v_part = PP_HOST;
                        n_host = sat_inc(r_host);
                    end
                    n_fc   = sat_inc(r_fc);
                    v_res0 = mk_res(b, FLD_PREFIX, sat_pos(r_fc, PFX_LIM), r_fc < PFX_LIM,
                                    v_part, n_bang && n_ata && !n_atb,
                                    n_trail, n_ptr, n_ttr, n_status);
                    v_cnt  = 2'd1;
                end
            end
            PH_PRESP: begin
                if (b == CH_SPACE) begin
                    v_res0 = mk_res(b, FLD_DELIM, '0, 1'b0, PP_NICK, uf,
                                    n_trail, n_ptr, n_ttr, n_status);
                    v_cnt  = 2'd1;
                end else begin
                    v_cmd = 1'b1;
                end
            end
            PH_CMD: begin
                if (b == CH_SPACE) begin
                    n_phase = PH_CMDSP;
                    n_fc    = '0;
                    v_res0  = mk_res(b, FLD_DELIM, '0, 1'b0, PP_NICK, uf,
                                     n_trail, n_ptr, n_ttr, n_status);
                    v_cnt   = 2'd1;
                end else begin
                    v_cmd = 1'b1;
                end
            end
            PH_CMDSP: begin
                n_fc = '0;
                if (b == CH_SPACE) begin
                    v_res0 = mk_res(b, FLD_DELIM, '0, 1'b0, PP_NICK, uf,
                                    n_trail, n_ptr, n_ttr, n_status);
                end else if (b == CH_COLON) begin
                    n_trail = 1'b1;
                    n_phase = PH_TRAIL;
                    v_res0  = mk_res(b, FLD_DELIM, '0, 1'b0, PP_NICK, uf,
                                     n_trail, n_ptr, n_ttr, n_status);
                end else begin
                    n_phase = PH_PARAMS;
                    n_fc    = sat_inc('0);
                    v_res0  = mk_res(b, FLD_PARAMS, '0, 1'b1, PP_NICK, uf,
                                     n_trail, n_ptr, n_ttr, n_status);
                end
                v_cnt = 2'd1;
            end
            PH_PARAMS: begin
                if (r_held) begin
                    n_held = 1'b0;
                    if (b == CH_COLON) begin
                        v_res0  = mk_res(CH_SPACE, FLD_DELIM, '0, 1'b0, PP_NICK, uf,
                                         n_trail, n_ptr, n_ttr, n_status);
                        n_trail = 1'b1;
                        n_phase = PH_TRAIL;
                        n_fc    = '0;
                        v_res1  = mk_res(b, FLD_DELIM, '0, 1'b0, PP_NICK, uf,
                                         n_trail, n_ptr, n_ttr, n_status);
                        v_cnt   = 2'd2;
                        v_skip  = 1'b1;
                    end else begin
                        if (n_fc >= LINE_LIM) begin
                            n_ptr = 1'b1;
                        end
                        v_res0 = mk_res(CH_SPACE, FLD_PARAMS, sat_pos(n_fc, LINE_LIM),
                                        n_fc < LINE_LIM, PP_NICK, uf,
                                        n_trail, n_ptr, n_ttr, n_status);
                        n_fc   = sat_inc(n_fc);
                        v_cnt  = 2'd1;
                    end
                end
                if (!v_skip) begin
                    if (b == CH_SPACE && !eol) begin
                        n_held = 1'b1;
                    end else begin
                        if (n_fc >= LINE_LIM) begin
                            n_ptr = 1'b1;
                        end
                        v_tmp = mk_res(b, FLD_PARAMS, sat_pos(n_fc, LINE_LIM),
                                       n_fc < LINE_LIM, PP_NICK, uf,
                                       n_trail, n_ptr, n_ttr, n_status);
                        n_fc  = sat_inc(n_fc);
                        if (v_cnt == '0) begin
                            v_res0 = v_tmp;
                        end else begin
                            v_res1 = v_tmp;
                        end
                        v_cnt = v_cnt + 1'b1;
                    end
                end
            end
            PH_TRAIL: begin
                if (r_fc >= LINE_LIM) begin
                    n_ttr = 1'b1;
                end
                n_fc   = sat_inc(r_fc);
                v_res0 = mk_res(b, FLD_TRAIL, sat_pos(r_fc, LINE_LIM), r_fc < LINE_LIM,
                                PP_NICK, uf, n_trail, n_ptr, n_ttr, n_status);
                v_cnt  = 2'd1;
            end
            default: begin
                v_res0 = mk_res(b, FLD_DELIM, '0, 1'b0, PP_NICK, uf,
                                n_trail, n_ptr, n_ttr, n_status);
                v_cnt  = 2'd1;
            end
        endcase

        if (v_cmd) begin
            if (r_fc >= CMD_LIM) begin
                v_drop    = 1'b1;
                v_drop_st = ST_CMD_LONG;
            end else begin
                n_phase = PH_CMD;
                n_fc    = sat_inc(r_fc);
                v_res0  = mk_res(b, FLD_CMD, r_fc[POS_W-1:0], 1'b1, PP_NICK, uf,
                                 n_trail, n_ptr, n_ttr, n_status);
                v_cnt   = 2'd1;
            end
        end

        if (v_drop) begin
            if (n_status == ST_OK) begin
                n_status = v_drop_st;
            end
            n_phase = PH_DROP;
            v_res0  = mk_res(b, FLD_DELIM, '0, 1'b0, PP_NICK, uf,
                             n_trail, n_ptr, n_ttr, n_status);
            v_cnt   = 2'd1;
        end

        if (eol) begin
            if (v_cnt == 2'd2) begin
                v_res1.last = 1'b1;
            end else begin
                v_res0.last = 1'b1;
            end
            n_phase  = PH_START;
            n_fc     = '0;
            n_nick   = '0;
            n_user   = '0;
            n_host   = '0;
            n_bang   = 1'b0;
            n_atb    = 1'b0;
            n_ata    = 1'b0;
            n_held   = 1'b0;
            n_status = ST_OK;
            n_trail  = 1'b0;
            n_ptr    = 1'b0;
            n_ttr    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_fc     <= '0;
            r_nick   <= '0;
            r_user   <= '0;
            r_host   <= '0;
            r_bang   <= 1'b0;
            r_atb    <= 1'b0;
            r_ata    <= 1'b0;
            r_held   <= 1'b0;
            r_status <= ST_OK;
            r_trail  <= 1'b0;
            r_ptr    <= 1'b0;
            r_ttr    <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_fc     <= n_fc;
            r_nick   <= n_nick;
            r_user   <= n_user;
            r_host   <= n_host;
            r_bang   <= n_bang;
            r_atb    <= n_atb;
            r_ata    <= n_ata;
            r_held   <= n_held;
            r_status <= n_status;
            r_trail  <= n_trail;
            r_ptr    <= n_ptr;
            r_ttr    <= n_ttr;
        end
    end

    assign o_res.cnt  = v_cnt;
    assign o_res.res0 = v_res0;
    assign o_res.res1 = v_res1;

    assign o_stat.line_start = (r_phase == PH_START) && !r_held && (r_fc == '0);
    assign o_stat.held       = r_held;

endmodule

### sv/imlp_outq.sv
`timescale 1ns / 1ps

module imlp_outq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [imlp_pkg::QC_W-1:0] i_push_cnt,
    input  imlp_pkg::t_out        i_d0,
    input  imlp_pkg::t_out        i_d1,
    input  logic                  i_stall,
    output logic                  o_valid,
    output imlp_pkg::t_out        o_data,
    output logic                  o_room
);
    import imlp_pkg::*;

    t_out            r_q [Q_DEPTH];
    t_out            n_q [Q_DEPTH];
    logic [QC_W-1:0] r_cnt, n_cnt;
    logic            v_pop;
    logic [QC_W-1:0] v_base;

    always_comb begin
        v_pop  = (r_cnt != '0) && !i_stall;
        v_base = r_cnt - QC_W'(v_pop);
        for (int i = 0; i < Q_DEPTH; i++) begin
            n_q[i] = r_q[i];
        end
        if (v_pop) begin
            for (int i = 0; i < Q_DEPTH - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
        end
        for (int i = 0; i < Q_DEPTH; i++) begin
            if (i_push_cnt != '0 && QC_W'(i) == v_base) begin
                n_q[i] = i_d0;
            end
            if (i_push_cnt == QC_W'(2) && QC_W'(i) == v_base + 1'b1) begin
                n_q[i] = i_d1;
            end
        end
        n_cnt = v_base + i_push_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < Q_DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[0];
    assign o_room  = (r_cnt <= QC_W'(Q_DEPTH - 2));

endmodule

### sim/irc_line_tag_checker.sv
`timescale 1ns / 1ps

module irc_line_tag_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  imlp_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  imlp_pkg::t_out i_out_data,
    output int             o_fail_count,
    output int             o_pending
);

    import imlp_pkg::*;

    t_phase           ph;
    logic [CNT_W-1:0] fcnt;
    logic [CNT_W-1:0] ncnt;
    logic [CNT_W-1:0] ucnt;
    logic [CNT_W-1:0] hcnt;
    logic             bang;
    logic             at_pre;
    logic             at_post;
    logic             held;
    t_status          lst;
    logic             fl_trail;
    logic             fl_ptr;
    logic             fl_ttr;

    t_out tag_buf[2];
    int   tag_n;
    t_out expected_tags[$];
    t_out want;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] x);
        return (&x) ? x : x + 1'b1;
    endfunction

    function automatic logic [POS_W-1:0] clip(input logic [CNT_W-1:0] idx, input int size);
        int m;
        m = (int'(idx) < size - 1) ? int'(idx) : size - 1;
        return m[POS_W-1:0];
    endfunction

    function automatic string show(input t_out r);
        return $sformatf({"byte=%02h field=%0d pos=%0d keep=%0b part=%0d uf=%0b trl=%0b ",
                          "ptr=%0b ttr=%0b st=%0d last=%0b"},
                         r.out_byte, r.field, r.position, r.keep, r.prefix_part, r.user_form,
                         r.trail_found, r.params_truncated, r.trailing_truncated, r.status,
                         r.last);
    endfunction

    task automatic note(input logic [7:0] b, input t_field fld, input logic [POS_W-1:0] pos,
                        input logic keep, input t_part part);
        t_out r;
        r.out_byte           = b;
        r.field              = fld;
        r.position           = pos;
        r.keep               = keep;
        r.prefix_part        = part;
        r.user_form          = bang && at_post && !at_pre;
        r.trail_found        = fl_trail;
        r.params_truncated   = fl_ptr;
        r.trailing_truncated = fl_ttr;
        r.status             = lst;
        r.last               = 1'b0;
        tag_buf[tag_n]       = r;
        tag_n++;
    endtask

    task automatic note_delim(input logic [7:0] b);
        note(b, FLD_DELIM, '0, 1'b0, PP_NICK);
    endtask

    task automatic clear_line();
        ph       = PH_START;
        fcnt     = '0;
        ncnt     = '0;
        ucnt     = '0;
        hcnt     = '0;
        bang     = 1'b0;
        at_pre   = 1'b0;
        at_post  = 1'b0;
        held     = 1'b0;
        lst      = ST_OK;
        fl_trail = 1'b0;
        fl_ptr   = 1'b0;
        fl_ttr   = 1'b0;
    endtask

    task automatic drop_rest(input logic [7:0] b, input t_status st);
        if (lst == ST_OK)
            lst = st;
        ph = PH_DROP;
        note_delim(b);
    endtask

    task automatic params_char(input logic [7:0] b);
        logic fits;
        fits = int'(fcnt) < LINE_BYTES - 1;
        if (!fits)
            fl_ptr = 1'b1;
        note(b, FLD_PARAMS, clip(fcnt, LINE_BYTES), fits, PP_NICK);
        fcnt = bump(fcnt);
    endtask

    task automatic trail_char(input logic [7:0] b);
        logic fits;
        fits = int'(fcnt) < LINE_BYTES - 1;
        if (!fits)
            fl_ttr = 1'b1;
        note(b, FLD_TRAIL, clip(fcnt, LINE_BYTES), fits, PP_NICK);
        fcnt = bump(fcnt);
    endtask

    task automatic open_trail(input logic [7:0] b);
        fl_trail = 1'b1;
        ph       = PH_TRAIL;
        fcnt     = '0;
        note_delim(b);
    endtask

    task automatic cmd_char(input logic [7:0] b);
        if (int'(fcnt) >= COMMAND_BYTES - 1) begin
            drop_rest(b, ST_CMD_LONG);
        end else begin
            ph = PH_CMD;
            note(b, FLD_CMD, fcnt[POS_W-1:0], 1'b1, PP_NICK);
            fcnt = bump(fcnt);
        end
    endtask

    task automatic prefix_char(input logic [7:0] b);
        t_part            part;
        logic [CNT_W-1:0] idx;
        part = PP_NICK;
        idx  = fcnt;
        if (at_pre) begin
            ncnt = bump(ncnt);
        end else if (!bang) begin
            if (b == CH_BANG) begin
                bang = 1'b1;
                part = PP_SEP;
            end else begin
                if (b == CH_AT)
                    at_pre = 1'b1;
                ncnt = bump(ncnt);
            end
        end else if (!at_post) begin
            if (b == CH_AT) begin
                at_post = 1'b1;
                part    = PP_SEP;
            end else begin
                part = PP_USER;
                ucnt = bump(ucnt);
            end
        end else begin
            part = PP_HOST;
            hcnt = bump(hcnt);
        end
        fcnt = bump(fcnt);
        note(b, FLD_PREFIX, clip(idx, PREFIX_BYTES), int'(idx) < PREFIX_BYTES - 1, part);
    endtask

    task automatic prefix_close(input logic [7:0] b);
        if (int'(fcnt) >= PREFIX_BYTES) begin
            drop_rest(b, ST_PFX_LONG);
        end else if (bang && at_post && !at_pre &&
                     (int'(ncnt) >= NICK_BYTES || int'(ucnt) >= NICK_BYTES ||
                      int'(hcnt) >= HOST_BYTES)) begin
            drop_rest(b, ST_PART_LONG);
        end else begin
            ph   = PH_PRESP;
            fcnt = '0;
            note_delim(b);
        end
    endtask

    task automatic predict_tags(input t_in x);
        logic [7:0] b;
        logic       eol;
        logic       opened;
        b      = x.in_byte;
        eol    = x.end_of_line;
        opened = 1'b0;
        tag_n  = 0;
        case (ph)
            PH_START: begin
                if (b == CH_COLON) begin
                    if (eol) begin
                        drop_rest(b, ST_NO_SPACE);
                    end else begin
                        ph   = PH_PREFIX;
                        fcnt = '0;
                        note_delim(b);
                    end
                end else if (b == CH_SPACE) begin
                    ph = PH_CMDSP;
                    note_delim(b);
                end else begin
                    cmd_char(b);
                end
            end
            PH_PREFIX: begin
                if (b == CH_SPACE)
                    prefix_close(b);
                else if (eol)
                    drop_rest(b, ST_NO_SPACE);
                else
                    prefix_char(b);
            end
            PH_PRESP: begin
                if (b == CH_SPACE)
                    note_delim(b);
                else
                    cmd_char(b);
            end
            PH_CMD: begin
                if (b == CH_SPACE) begin
                    ph   = PH_CMDSP;
                    fcnt = '0;
                    note_delim(b);
                end else begin
                    cmd_char(b);
                end
            end
            PH_CMDSP: begin
                fcnt = '0;
                if (b == CH_SPACE) begin
                    note_delim(b);
                end else if (b == CH_COLON) begin
                    open_trail(b);
                end else begin
                    ph = PH_PARAMS;
                    params_char(b);
                end
            end
            PH_PARAMS: begin
                if (held) begin
                    held = 1'b0;
                    if (b == CH_COLON) begin
                        note_delim(CH_SPACE);
                        open_trail(b);
                        opened = 1'b1;
                    end else begin
                        params_char(CH_SPACE);
                    end
                end
                if (!opened) begin
                    if (b == CH_SPACE && !eol)
                        held = 1'b1;
                    else
                        params_char(b);
                end
            end
            PH_TRAIL: trail_char(b);
            default:  note_delim(b);
        endcase
        if (eol) begin
            if (tag_n > 0)
                tag_buf[tag_n-1].last = 1'b1;
            clear_line();
        end
        for (int i = 0; i < tag_n; i++)
            expected_tags.push_back(tag_buf[i]);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_line();
            expected_tags.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_tags.size() == 0) begin
                    $display("%0t: unexpected result, got %s", $time, show(i_out_data));
                    o_fail_count++;
                end else begin
                    want = expected_tags.pop_front();
                    if (i_out_data !== want) begin
                        $display("%0t: mismatch, expected %s", $time, show(want));
                        $display("%0t:           actual   %s", $time, show(i_out_data));
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_tags(i_in_data);
        end
        o_pending = expected_tags.size();
    end

endmodule

### sim/irc_message_line_parser_test.sv
`timescale 1ns / 1ps

module irc_message_line_parser_test;

    import imlp_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_BYTES = 300;
    localparam int RUN_NAME = 0;
    localparam int RUN_PREFIX = 1;
    localparam int RUN_WORD = 2;
    localparam int RUN_TEXT = 3;
    localparam int RUN_ANY = 4;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in  in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;
    int   fail_count;
    int   pending;

    int idle_pct = 0;
    int stall_pct = 0;
    int sent = 0;
    int cycles = 0;
    logic [7:0] line_q[$];

    irc_message_line_parser dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    irc_line_tag_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] pick_char(input int mix);
        int r;
        r = $urandom_range(99);
        case (mix)
            RUN_NAME: begin
                pick_char = 8'($urandom_range(126, 33));
                while (pick_char == CH_BANG || pick_char == CH_AT || pick_char == CH_COLON)
                    pick_char = 8'($urandom_range(126, 33));
            end
            RUN_PREFIX: pick_char = (r < 15) ? CH_BANG : (r < 30) ? CH_AT : pick_char(RUN_NAME);
            RUN_WORD:   pick_char = (r < 15) ? CH_COLON : 8'($urandom_range(126, 33));
            RUN_TEXT:   pick_char = (r < 25) ? CH_SPACE : (r < 35) ? CH_COLON :
                                    8'($urandom_range(126, 33));
            default: begin
                if (r < 10)
                    pick_char = CH_SPACE;
                else if (r < 18)
                    pick_char = CH_COLON;
                else if (r < 24)
                    pick_char = CH_BANG;
                else if (r < 30)
                    pick_char = CH_AT;
                else
                    pick_char = 8'($urandom_range(255));
            end
        endcase
    endfunction

    task automatic add_run(input int n, input int mix);
        for (int i = 0; i < n; i++)
            line_q.push_back(pick_char(mix));
    endtask

    task automatic add_rep(input logic [7:0] c, input int n);
        for (int i = 0; i < n; i++)
            line_q.push_back(c);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eol);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {b, eol};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_q.size(); i++)
            send_byte(line_q[i], i == line_q.size() - 1);
        sent += line_q.size();
        line_q.delete();
    endtask

    // hold input until every pending result has drained
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    function automatic int part_len(input int size);
        return ($urandom_range(9) == 0) ? $urandom_range(size + 1, size - 2) :
                                          $urandom_range(8);
    endfunction

    task automatic build_line();
        int k;
        int words;
        k = $urandom_range(9);
        if (k == 3 || k == 4) begin
            line_q.push_back(CH_COLON);
            add_run($urandom_range(12, 1), RUN_NAME);
        end else if (k >= 5 && k <= 7) begin
            line_q.push_back(CH_COLON);
            add_run(part_len(NICK_BYTES), RUN_NAME);
            line_q.push_back(CH_BANG);
            add_run(part_len(NICK_BYTES), RUN_NAME);
            line_q.push_back(CH_AT);
            add_run(part_len(HOST_BYTES), RUN_NAME);
        end else if (k == 8) begin
            line_q.push_back(CH_COLON);
            add_run($urandom_range(12), RUN_PREFIX);
        end else if (k == 9 && $urandom_range(3) == 0) begin
            line_q.push_back(CH_COLON);
            add_run($urandom_range(PREFIX_BYTES + 2, PREFIX_BYTES - 6), RUN_NAME);
        end
        if (line_q.size() != 0)
            add_rep(CH_SPACE, $urandom_range(2, 1));
        add_run(($urandom_range(9) == 0) ? $urandom_range(COMMAND_BYTES + 2, COMMAND_BYTES - 3)
                                         : $urandom_range(6, 1), RUN_NAME);
        words = $urandom_range(4);
        for (int i = 0; i < words; i++) begin
            add_rep(CH_SPACE, $urandom_range(2, 1));
            add_run($urandom_range(8, 1), RUN_WORD);
        end
        if ($urandom_range(1)) begin
            add_str(" :");
            add_run($urandom_range(20), RUN_TEXT);
        end else if ($urandom_range(3) == 0) begin
            line_q.push_back(CH_SPACE);
        end
    endtask

    task automatic random_line();
        int sel;
        int n;
        sel = $urandom_range(99);
        build_line();
        if (sel < 15) begin
            n = $urandom_range(line_q.size(), 1);
            while (line_q.size() > n)
                void'(line_q.pop_back());
        end else if (sel < 30) begin
            line_q.delete();
            add_run($urandom_range(12, 1), RUN_ANY);
        end
        send_line();
    endtask

    task automatic random_phase(input int sender_idle, input int receiver_stall);
        int start;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        start     = sent;
        while (sent - start < RANDOM_BYTES / 3)
            random_line();
        drain();
    endtask

    task automatic directed_lines();
        line_q.push_back(CH_COLON);
        send_line();
        add_str(":ab");
        send_line();
        add_str(" :x");
        send_line();
        add_str("P :");
        send_line();
        add_str("P a ");
        send_line();
        add_str("P a  b");
        send_line();
        add_str(":n!u@h Q x :y");
        send_line();
        add_str(":a@b!c R");
        send_line();
        line_q.push_back(8'h00);
        line_q.push_back(8'hFF);
        send_line();
    endtask

    task automatic boundary_lines();
        line_q.push_back(CH_COLON);
        add_rep("a", PREFIX_BYTES);
        add_str(" C x");
        send_line();
        for (int n = NICK_BYTES - 1; n <= NICK_BYTES; n++) begin
            line_q.push_back(CH_COLON);
            add_rep("n", n);
            add_str("!u@h C");
            send_line();
            add_str(":n!");
            add_rep("u", n);
            add_str("@h C");
            send_line();
        end
        for (int n = HOST_BYTES - 1; n <= HOST_BYTES; n++) begin
            add_str(":n!u@");
            add_rep("h", n);
            add_str(" C");
            send_line();
        end
        for (int n = COMMAND_BYTES - 1; n <= COMMAND_BYTES; n++) begin
            add_rep("C", n);
            add_str(" x");
            send_line();
        end
        add_str("C ");
        add_rep("p", LINE_BYTES - 3);
        add_str("  q r :z");
        send_line();
        add_str("C :");
        add_rep("t", LINE_BYTES + 2);
        send_line();
    endtask

    initial begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idle_pct  = 28;
        stall_pct = 56;
        directed_lines();
        drain();
        boundary_lines();
        drain();
        random_phase(28, 56);
        random_phase(56, 28);
        random_phase(0, 0);
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
sv/imlp_pkg.sv
sv/imlp_parser.sv
sv/imlp_outq.sv
sv/irc_message_line_parser.sv
sim/irc_line_tag_checker.sv
sim/irc_message_line_parser_test.sv
